/* rtl/core/deadline_timer_queue_macros.svh */
// ----------------------------------------------------------------------------
// Deadline timer queue assertion macros
// Clocked, reset-qualified implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_MACROS_SVH

// same-cycle implication
`define DTQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dtq_pkg.sv */
// ----------------------------------------------------------------------------
// Deadline timer queue package
// Field widths, operation and result codes, entry layout and sequencer states.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int OP_W        = 2;
    localparam int ID_W        = 16;
    localparam int TIME_W      = 48;
    localparam int KIND_W      = 3;
    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_ONE = TIME_W'(1);

    localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL   = 2'd1;
    localparam logic [OP_W-1:0] OP_POLL     = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SCHEDULED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NONE_DUE  = 3'd5;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] deadline;
    } entry_t;

    localparam int ENTRY_W = ID_W + TIME_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SC_RD,
        S_SC_CMP,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_CA_RD,
        S_CA_CMP,
        S_CS_RD,
        S_CS_WR,
        S_P_RD,
        S_P_CMP,
        S_EMIT
    } state_t;

endpackage

/* rtl/core/dtq_ram.sv */
// ----------------------------------------------------------------------------
// Deadline timer queue RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module dtq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/deadline_timer_queue.sv */
// ----------------------------------------------------------------------------
// Deadline timer queue
// Time-sorted task queue with schedule, cancel and poll transactions.
// ----------------------------------------------------------------------------
// Entries sit in one RAM as a circular buffer in deadline order; a sequencer
// walks them one entry at a time through the single read port, with a read
// state and a compare or write state for each entry visited. A schedule
// visits the entries it passes over and the entries it moves, a cancel at
// most the whole queue, and a poll each task it fires. Fired tasks leave by a
// head pointer advance, so polls move no data. Results leave through an
// output register; the next request is taken while the last result of a
// transaction still waits there.
module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [OP_W-1:0]   operation,
    input  logic [ID_W-1:0]   task_id,
    input  logic [TIME_W-1:0] time_value,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [KIND_W-1:0] result_kind,
    output logic [ID_W-1:0]   task_id_res,
    output logic [TIME_W-1:0] fire_time,
    output logic              last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int SW = IW + 1;
    localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);
    localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
    localparam logic [IW-1:0] ONE_I = IW'(1);

    state_t state_reg, state_next;

    logic [ID_W-1:0]   id_reg, id_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     pos_reg, pos_next;
    logic [IW-1:0]     count_reg, count_next;
    logic [AW-1:0]     head_reg, head_next;
    entry_t            pend_reg, pend_next;
    logic              have_pend_reg, have_pend_next;
    logic [KIND_W-1:0] rkind_reg, rkind_next;
    logic [ID_W-1:0]   rid_reg, rid_next;
    logic [TIME_W-1:0] rtime_reg, rtime_next;

    logic              ovalid_reg, ovalid_next;
    logic [KIND_W-1:0] okind_reg, okind_next;
    logic [ID_W-1:0]   oid_reg, oid_next;
    logic [TIME_W-1:0] otime_reg, otime_next;
    logic              olast_reg, olast_next;

    logic              we;
    logic [AW-1:0]     waddr;
    entry_t            wdata;
    logic [AW-1:0]     raddr;
    entry_t            rdata;

    logic              accept;
    logic              out_free;
    logic              scan_hit;
    logic              poll_due;
    logic              last_move;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [IW-1:0] idx);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(idx);
        if (sum >= CAP_S)
        begin
            sum = sum - CAP_S;
        end
        return sum[AW-1:0];
    endfunction

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !ovalid_reg || !res_stall;
    assign raddr     = phys(head_reg, idx_reg);
    assign scan_hit  = (idx_reg < count_reg) && (rdata.deadline <= t_reg);
    assign poll_due  = (idx_reg < count_reg) && (32'(idx_reg) < MAX_RESULTS)
                       && (rdata.deadline <= t_reg);
    assign last_move = ((idx_reg + ONE_I) == count_reg);

    dtq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority case (operation)
                        OP_SCHEDULE: state_next = (count_reg >= CAP_I) ? S_EMIT : S_SC_RD;
                        OP_CANCEL:   state_next = S_CA_RD;
                        OP_POLL:     state_next = S_P_RD;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_SC_RD:  state_next = S_SC_CMP;
            S_SC_CMP:
            begin
                priority if (scan_hit && rdata.deadline == t_reg && t_reg == TIME_MAX)
                    state_next = S_EMIT;
                else if (scan_hit)
                    state_next = S_SC_RD;
                else if (idx_reg == count_reg)
                    state_next = S_INS_WR;
                else
                    state_next = S_SH_RD;
            end
            S_SH_RD:  state_next = S_SH_WR;
            S_SH_WR:  state_next = (idx_reg == pos_reg) ? S_INS_WR : S_SH_RD;
            S_INS_WR: state_next = S_EMIT;
            S_CA_RD:  state_next = S_CA_CMP;
            S_CA_CMP:
            begin
                priority if (idx_reg == count_reg)
                    state_next = S_EMIT;
                else if (rdata.id == id_reg)
                    state_next = last_move ? S_EMIT : S_CS_RD;
                else
                    state_next = S_CA_RD;
            end
            S_CS_RD:  state_next = S_CS_WR;
            S_CS_WR:  state_next = last_move ? S_EMIT : S_CS_RD;
            S_P_RD:   state_next = S_P_CMP;
            S_P_CMP:
            begin
                priority if (!poll_due)
                    state_next = S_EMIT;
                else if (!have_pend_reg || out_free)
                    state_next = S_P_RD;
                else
                    state_next = S_P_CMP;
            end
            S_EMIT:   state_next = out_free ? S_IDLE : S_EMIT;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        id_next        = id_reg;
        t_next         = t_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        pend_next      = pend_reg;
        have_pend_next = have_pend_reg;
        rkind_next     = rkind_reg;
        rid_next       = rid_reg;
        rtime_next     = rtime_reg;
        ovalid_next    = ovalid_reg && res_stall;
        okind_next     = okind_reg;
        oid_next       = oid_reg;
        otime_next     = otime_reg;
        olast_next     = olast_reg;
        we             = 1'b0;
        waddr          = phys(head_reg, idx_reg);
        wdata          = rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    id_next        = task_id;
                    t_next         = time_value;
                    idx_next       = '0;
                    have_pend_next = 1'b0;
                    rkind_next     = KIND_REJECTED;
                    rid_next       = task_id;
                    rtime_next     = time_value;
                end
            end
            S_SC_CMP:
            begin
                priority if (scan_hit && rdata.deadline == t_reg && t_reg == TIME_MAX)
                begin
                    rkind_next = KIND_REJECTED;
                    rid_next   = id_reg;
                    rtime_next = t_reg;
                end
                else if (scan_hit)
                begin
                    if (rdata.deadline == t_reg)
                    begin
                        t_next = t_reg + TIME_ONE;
                    end
                    idx_next = idx_reg + ONE_I;
                end
                else
                begin
                    pos_next = idx_reg;
                    if (idx_reg != count_reg)
                    begin
                        idx_next = count_reg - ONE_I;
                    end
                end
            end
            S_SH_WR:
            begin
                we    = 1'b1;
                waddr = phys(head_reg, idx_reg + ONE_I);
                wdata = rdata;
                if (idx_reg != pos_reg)
                begin
                    idx_next = idx_reg - ONE_I;
                end
            end
            S_INS_WR:
            begin
                we          = 1'b1;
                waddr       = phys(head_reg, pos_reg);
                wdata.id    = id_reg;
                wdata.deadline = t_reg;
                count_next  = count_reg + ONE_I;
                rkind_next  = KIND_SCHEDULED;
                rid_next    = id_reg;
                rtime_next  = t_reg;
            end
            S_CA_CMP:
            begin
                priority if (idx_reg == count_reg)
                begin
                    rkind_next = KIND_NOT_FOUND;
                    rid_next   = id_reg;
                    rtime_next = '0;
                end
                else if (rdata.id == id_reg)
                begin
                    rkind_next = KIND_CANCELLED;
                    rid_next   = id_reg;
                    rtime_next = rdata.deadline;
                    idx_next   = idx_reg + ONE_I;
                    if (last_move)
                    begin
                        count_next = count_reg - ONE_I;
                    end
                end
                else
                begin
                    idx_next = idx_reg + ONE_I;
                end
            end
            S_CS_WR:
            begin
                we       = 1'b1;
                waddr    = phys(head_reg, idx_reg - ONE_I);
                wdata    = rdata;
                idx_next = idx_reg + ONE_I;
                if (last_move)
                begin
                    count_next = count_reg - ONE_I;
                end
            end
            S_P_CMP:
            begin
                priority if (!poll_due)
                begin
                    if (have_pend_reg)
                    begin
                        rkind_next = KIND_FIRED;
                        rid_next   = pend_reg.id;
                        rtime_next = pend_reg.deadline;
                        head_next  = phys(head_reg, idx_reg);
                        count_next = count_reg - idx_reg;
                    end
                    else
                    begin
                        rkind_next = KIND_NONE_DUE;
                        rid_next   = '0;
                        rtime_next = '0;
                    end
                end
                else if (!have_pend_reg || out_free)
                begin
                    if (have_pend_reg)
                    begin
                        ovalid_next = 1'b1;
                        okind_next  = KIND_FIRED;
                        oid_next    = pend_reg.id;
                        otime_next  = pend_reg.deadline;
                        olast_next  = 1'b0;
                    end
                    pend_next      = rdata;
                    have_pend_next = 1'b1;
                    idx_next       = idx_reg + ONE_I;
                end
                else
                begin
                    pend_next = pend_reg;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = rkind_reg;
                    oid_next    = rid_reg;
                    otime_next  = rtime_reg;
                    olast_next  = 1'b1;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            have_pend_reg <= 1'b0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            have_pend_reg <= have_pend_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        t_reg      <= t_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        pend_reg   <= pend_next;
        rkind_reg  <= rkind_next;
        rid_reg    <= rid_next;
        rtime_reg  <= rtime_next;
        okind_reg  <= okind_next;
        oid_reg    <= oid_next;
        otime_reg  <= otime_next;
        olast_reg  <= olast_next;
    end

    assign res_valid   = ovalid_reg;
    assign result_kind = okind_reg;
    assign task_id_res = oid_reg;
    assign fire_time   = otime_reg;
    assign last        = olast_reg;

endmodule

/* rtl/core/dtq_checker.sv */
// ----------------------------------------------------------------------------
// Deadline timer queue checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "deadline_timer_queue_macros.svh"

module dtq_checker
    import dtq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_stall,
    input logic [KIND_W-1:0] result_kind,
    input logic [ID_W-1:0]   task_id_res,
    input logic [TIME_W-1:0] fire_time,
    input logic              last
);

    `DTQ_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid, "stalled transaction dropped")
    `DTQ_ASSERT_NOW(a_kind_range, res_valid, result_kind <= KIND_NONE_DUE, "bad result kind")
    `DTQ_ASSERT_NOW(a_single_last, res_valid && result_kind != KIND_FIRED, last, "single result not last")
    `DTQ_ASSERT_NOW(a_none_due_zero, res_valid && result_kind == KIND_NONE_DUE, task_id_res == '0 && fire_time == '0, "none-due payload not zero")
    `DTQ_ASSERT_NOW(a_not_found_zero, res_valid && result_kind == KIND_NOT_FOUND, fire_time == '0, "not-found time not zero")

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);
